@@ hw/rtl/utq_pkg.sv @@
package utq_pkg;

  localparam int RING_DEPTH = 16;
  localparam int IDX_W      = $clog2(RING_DEPTH);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

  // item kinds
  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_READY = 1'b1;

  // ninth bit rules
  localparam logic [1:0] PAR_MARK  = 2'd0;
  localparam logic [1:0] PAR_SPACE = 2'd1;
  localparam logic [1:0] PAR_EVEN  = 2'd2;
  localparam logic [1:0] PAR_ODD   = 2'd3;

  localparam logic [1:0] PAR_RESET = PAR_EVEN;

  typedef struct packed {
    logic send_valid;
    logic add_rejected;
    logic drain_enabled;
    logic queue_finished;
    logic drive_transmit;
  } ctrl_res_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic       tx_reg_empty;
  } in_item_t;

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] n;
    if (idx == LAST_IDX) begin
      n = '0;
    end else begin
      n = idx + IDX_W'(1);
    end
    return n;
  endfunction

endpackage

@@ hw/rtl/utq_if.sv @@
interface utq_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  logic       tx_reg_empty;

  modport source (output valid, kind, data_byte, tx_reg_empty, input ready);
  modport sink   (input valid, kind, data_byte, tx_reg_empty, output ready);
endinterface

interface utq_out_if;
  logic       valid;
  logic       ready;
  logic       send_valid;
  logic [7:0] send_byte;
  logic       send_ninth_bit;
  logic       add_rejected;
  logic       drain_enabled;
  logic       queue_finished;
  logic       drive_transmit;

  modport source (output valid, send_valid, send_byte, send_ninth_bit, add_rejected,
                  drain_enabled, queue_finished, drive_transmit, input ready);
  modport sink   (input valid, send_valid, send_byte, send_ninth_bit, add_rejected,
                  drain_enabled, queue_finished, drive_transmit, output ready);
endinterface

@@ hw/rtl/uart_tx_ring_queue_with_parity_top.sv @@
// channel  dir  handshake       payload
// in_ch    in   valid/ready     kind, data_byte, tx_reg_empty
// out_ch   out  valid/ready     send_valid, send_byte, send_ninth_bit, add_rejected,
//                               drain_enabled, queue_finished, drive_transmit
// cfg      in   cfg_wr_en       cfg_wr_data = parity_mode
//
// One item per cycle while out_ch is not stalled; a result passes through the ring read
// register, then the output register with the ninth bit.
// Ring indices and flags update at the input transfer, so items may follow back to back.
// Synchronous active-low reset clears indices, flags and valids; parity_mode resets to even.
// out_ch stall holds the output register, then the read stage, then in_ch.ready drops.
module uart_tx_ring_queue_with_parity_top (
  input  logic       clk,
  input  logic       rst_n,
  utq_in_if.sink     in_ch,
  utq_out_if.source  out_ch,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data
);
  import utq_pkg::*;

  logic             s1_valid_r, s1_valid_nxt;
  logic             s1_adv;
  logic             accept;
  logic             out_free;
  in_item_t         item;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [7:0]       wr_data;
  logic [IDX_W-1:0] rd_addr;
  logic [7:0]       rd_data;
  ctrl_res_t        res;

  assign s1_adv      = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign accept      = in_ch.valid && in_ch.ready;

  assign item.kind         = in_ch.kind;
  assign item.data_byte    = in_ch.data_byte;
  assign item.tx_reg_empty = in_ch.tx_reg_empty;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  utq_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .item    (item),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .res     (res)
  );

  utq_ring u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  utq_out_stage u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .load        (s1_adv),
    .res         (res),
    .rd_data     (rd_data),
    .free        (out_free),
    .out_ch      (out_ch)
  );

endmodule

@@ hw/rtl/utq_ring.sv @@
module utq_ring (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [utq_pkg::IDX_W-1:0] wr_addr,
  input  logic [7:0]                wr_data,
  input  logic                      rd_en,
  input  logic [utq_pkg::IDX_W-1:0] rd_addr,
  output logic [7:0]                rd_data
);
  import utq_pkg::*;

  logic [7:0] mem [RING_DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hw/rtl/utq_ctrl.sv @@
module utq_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      accept,
  input  utq_pkg::in_item_t         item,
  output logic                      wr_en,
  output logic [utq_pkg::IDX_W-1:0] wr_addr,
  output logic [7:0]                wr_data,
  output logic [utq_pkg::IDX_W-1:0] rd_addr,
  output utq_pkg::ctrl_res_t        res
);
  import utq_pkg::*;

  logic [IDX_W-1:0] write_index_r, write_index_nxt;
  logic [IDX_W-1:0] read_index_r, read_index_nxt;
  logic             drain_on_r, drain_on_nxt;
  logic             finished_r, finished_nxt;
  logic             direction_r, direction_nxt;
  ctrl_res_t        res_r, res_nxt;
  logic [IDX_W-1:0] wr_next;
  logic             full;
  logic             empty;

  assign wr_next = next_slot(write_index_r);
  assign full    = (wr_next == read_index_r);
  assign empty   = (read_index_r == write_index_r);

  always_comb begin
    write_index_nxt = write_index_r;
    read_index_nxt  = read_index_r;
    drain_on_nxt    = drain_on_r;
    finished_nxt    = finished_r;
    direction_nxt   = direction_r;
    wr_en           = 1'b0;
    res_nxt         = '0;
    if (accept) begin
      case (item.kind)
        KIND_ADD: begin
          if (full) begin
            res_nxt.add_rejected = 1'b1;
          end else begin
            wr_en           = 1'b1;
            write_index_nxt = wr_next;
            if (item.tx_reg_empty && !drain_on_r) begin
              direction_nxt = 1'b1;
              drain_on_nxt  = 1'b1;
              finished_nxt  = 1'b0;
            end
          end
        end
        KIND_READY: begin
          if (empty) begin
            drain_on_nxt  = 1'b0;
            finished_nxt  = 1'b1;
            direction_nxt = 1'b0;
          end else begin
            res_nxt.send_valid = 1'b1;
            read_index_nxt     = next_slot(read_index_r);
          end
        end
        default: begin
        end
      endcase
    end
    res_nxt.drain_enabled  = drain_on_nxt;
    res_nxt.queue_finished = finished_nxt;
    res_nxt.drive_transmit = direction_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_index_r <= '0;
      read_index_r  <= '0;
      drain_on_r    <= 1'b0;
      finished_r    <= 1'b0;
      direction_r   <= 1'b0;
    end else begin
      write_index_r <= write_index_nxt;
      read_index_r  <= read_index_nxt;
      drain_on_r    <= drain_on_nxt;
      finished_r    <= finished_nxt;
      direction_r   <= direction_nxt;
    end
  end

  // result flags travel alongside the registered ring read
  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign wr_addr = write_index_r;
  assign wr_data = item.data_byte;
  assign rd_addr = read_index_r;
  assign res     = res_r;

endmodule

@@ hw/rtl/utq_out_stage.sv @@
module utq_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_wr_data,
  input  logic               load,
  input  utq_pkg::ctrl_res_t res,
  input  logic [7:0]         rd_data,
  output logic               free,
  utq_out_if.source          out_ch
);
  import utq_pkg::*;

  logic [1:0] mode_r;
  logic       out_valid_r, out_valid_nxt;
  ctrl_res_t  res_r;
  logic [7:0] byte_r;
  logic       ninth_r;
  logic [7:0] byte_nxt;
  logic       ninth_nxt;
  logic       par;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= PAR_RESET;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
    end
  end

  assign par = ^rd_data;

  always_comb begin
    case (mode_r)
      PAR_MARK:  ninth_nxt = 1'b1;
      PAR_SPACE: ninth_nxt = 1'b0;
      PAR_EVEN:  ninth_nxt = par;
      PAR_ODD:   ninth_nxt = ~par;
      default:   ninth_nxt = 1'b0;
    endcase
    byte_nxt = rd_data;
    // nothing sent: byte and ninth bit read as zero
    if (!res.send_valid) begin
      ninth_nxt = 1'b0;
      byte_nxt  = '0;
    end
  end

  assign free = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r   <= res;
      byte_r  <= byte_nxt;
      ninth_r <= ninth_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.send_valid     = res_r.send_valid;
  assign out_ch.send_byte      = byte_r;
  assign out_ch.send_ninth_bit = ninth_r;
  assign out_ch.add_rejected   = res_r.add_rejected;
  assign out_ch.drain_enabled  = res_r.drain_enabled;
  assign out_ch.queue_finished = res_r.queue_finished;
  assign out_ch.drive_transmit = res_r.drive_transmit;

endmodule
